FILE: design/ndst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndst_pkg: shared types and constants
// Constants of the second tick unit, the config bundle and divider status.
// ----------------------------------------------------------------------------
package ndst_pkg;

  // microseconds per second, constant multiplier operand
  localparam logic [19:0] UsPerSec     = 20'd1000000;
  localparam logic [30:0] RateMax      = 31'h7FFF_FFFF;
  localparam logic [30:0] NominalReset = 31'd1000000;
  localparam logic [15:0] DivisorReset = 16'd1000;

  // register indexes (bit 2 of the byte address)
  localparam logic RegNominal = 1'b0;
  localparam logic RegDivisor = 1'b1;

  // shared divider: dividend is left-aligned in DivW bits
  localparam int unsigned DivW  = 84;
  localparam int unsigned StepW = 7;
  localparam logic [StepW-1:0] RateSteps = 7'd84;
  localparam logic [StepW-1:0] CorrSteps = 7'd64;

  // ceil(2^35 / 11): x * AvgRecip >> 35 is exactly x / 11 for any 35-bit x
  localparam logic [31:0] AvgRecip = 32'd3123612579;

  typedef struct packed {
    logic        nominal_wr;
    logic [30:0] nominal;
    logic [15:0] divisor;
  } cfg_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [63:0] quo;
  } div_res_t;

endpackage : ndst_pkg
`default_nettype wire

FILE: design/ntp_disciplined_second_tick_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntp_disciplined_second_tick_unit: NTP-disciplined one-second tick
// Seconds count and next-second deadline on a microsecond timer, calibrated
// from NTP samples.
// ----------------------------------------------------------------------------
// One item is in work at a time; s_axis_tready is high only while the
// sequencer is idle. A tick (tuser = 1) goes from the input transfer straight
// to the result state; an NTP sample first runs the microsecond conversion,
// and a later sample spends most of its time in the single bit-serial
// divider, which is shared by the rate measure (84 steps) and the error
// correction divide (64 steps). A later sample whose NTP interval is zero
// skips the rate measure and the average. The (10*old + new)/11 average
// is a multiply by a 2^35/11 reciprocal, done in two 16-bit halves in
// S_AVG_LO and S_AVG_HI. A single 32x20 constant multiplier by 1000000
// serves all the microsecond conversions. A result that waits downstream
// holds the sequencer in its last state until it is taken.
// ----------------------------------------------------------------------------
module ntp_disciplined_second_tick_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input items
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] ntp_seconds, [63:32] ntp_fraction, [127:64] timer_us
  input  wire logic [127:0] s_axis_tdata,
  // [0] command (0 = NTP sample, 1 = tick)
  input  wire logic         s_axis_tuser,
  // results
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [63:0] deadline_us, [95:64] seconds_now, [127:96] interval_us,
  // [158:128] rate_estimate, [159] zero_interval_error
  output logic [159:0]      m_axis_tdata,
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ndst_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE      = 19'h00001,
    S_MUL_SEC   = 19'h00002,
    S_MUL_FRAC  = 19'h00004,
    S_NTP       = 19'h00008,
    S_SYNC      = 19'h00010,
    S_DIFF      = 19'h00020,
    S_MUL_ALO   = 19'h00040,
    S_MUL_AHI   = 19'h00080,
    S_PROD      = 19'h00100,
    S_RDIV_ST   = 19'h00200,
    S_RDIV_WAIT = 19'h00400,
    S_AVG_LO    = 19'h00800,
    S_AVG_HI    = 19'h01000,
    S_ERRMUL    = 19'h02000,
    S_ERR       = 19'h04000,
    S_CDIV_ST   = 19'h08000,
    S_CDIV_WAIT = 19'h10000,
    S_SUM       = 19'h20000,
    S_DONE      = 19'h40000
  } state_e;

  localparam logic signed [65:0] SumMax = 66'sd2147483647;
  localparam logic signed [65:0] SumMin = -66'sd2147483648;

  state_e state_q, state_d;

  cfg_t     cfg;
  div_res_t div_res;

  // architectural state
  logic        synced_q;
  logic [30:0] rate_avg_q;
  logic [31:0] interval_q;
  logic [63:0] base_timer_q;
  logic [63:0] base_ntp_q;
  logic [63:0] deadline_q;
  logic [31:0] second_count_q;

  // per-item work registers
  logic [31:0]     secs_q;
  logic [31:0]     frac_q;
  logic [63:0]     tnow_q;
  logic [51:0]     mul_q;
  logic [63:0]     ntp_us_q;
  logic [63:0]     a_q;
  logic [63:0]     d_q;
  logic            neg_q;
  logic            err_q;
  logic [DivW-1:0] prod_q;
  logic [34:0]     avg_num_q;
  logic [50:0]     avg_prod_q;
  logic [63:0]     emag_q;
  logic            eneg_q;
  logic [63:0]     corr_q;

  logic         m_valid_q;
  logic [159:0] m_data_q;

  logic [31:0]      mul_a;
  logic             div_start;
  logic [DivW-1:0]  div_dividend;
  logic [63:0]      div_divisor;
  logic [StepW-1:0] div_steps;
  logic [15:0]      divisor_eff;

  logic        in_xfer;
  logic        out_load;
  logic [63:0] ntp_diff;
  logic [63:0] timer_diff;
  logic [63:0] err_diff;
  logic [30:0] tps;
  logic signed [65:0] sum;
  logic [15:0] avg_coef;
  logic [50:0] avg_mul;
  logic [66:0] avg_sum;

  ndst_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ndst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .res_o      (div_res)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign out_load      = (state_q == S_DONE) & (~m_valid_q | m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign divisor_eff = (cfg.divisor == 16'd0) ? 16'd1 : cfg.divisor;
  assign ntp_diff    = ntp_us_q - base_ntp_q;
  assign timer_diff  = tnow_q - base_timer_q;
  assign err_diff    = {12'b0, mul_q} - ntp_us_q;

  // average / 11: low half of the reciprocal first, then high half and sum
  assign avg_coef = (state_q == S_AVG_HI) ? AvgRecip[31:16] : AvgRecip[15:0];
  assign avg_mul  = 51'(avg_num_q) * 51'(avg_coef);
  assign avg_sum  = {16'b0, avg_prod_q} + {avg_mul, 16'b0};

  // measured ticks per second, saturated; opposite signs give zero
  always_comb begin
    if (neg_q) begin
      tps = '0;
    end else if (div_res.ovf || (div_res.quo[63:31] != '0)) begin
      tps = RateMax;
    end else begin
      tps = div_res.quo[30:0];
    end
  end

  always_comb begin
    if (eneg_q) begin
      sum = $signed({35'b0, rate_avg_q}) - $signed({2'b0, corr_q});
    end else begin
      sum = $signed({35'b0, rate_avg_q}) + $signed({2'b0, corr_q});
    end
  end

  // shared multiplier operand
  always_comb begin
    unique case (state_q)
      S_MUL_FRAC: mul_a = frac_q;
      S_MUL_ALO:  mul_a = a_q[31:0];
      S_MUL_AHI:  mul_a = a_q[63:32];
      S_ERRMUL:   mul_a = second_count_q;
      default:    mul_a = secs_q;
    endcase
  end

  // shared divider operands, dividends left-aligned
  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod_q;
    div_divisor  = d_q;
    div_steps    = RateSteps;
    unique case (state_q)
      S_RDIV_ST: begin
        div_start = 1'b1;
      end
      S_CDIV_ST: begin
        div_start    = 1'b1;
        div_dividend = {emag_q, 20'b0};
        div_divisor  = {48'b0, divisor_eff};
        div_steps    = CorrSteps;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_xfer) state_d = s_axis_tuser ? S_DONE : S_MUL_SEC;
      S_MUL_SEC:   state_d = S_MUL_FRAC;
      S_MUL_FRAC:  state_d = S_NTP;
      S_NTP:       state_d = synced_q ? S_DIFF : S_SYNC;
      S_SYNC:      state_d = S_DONE;
      S_DIFF:      state_d = (ntp_diff == '0) ? S_ERRMUL : S_MUL_ALO;
      S_MUL_ALO:   state_d = S_MUL_AHI;
      S_MUL_AHI:   state_d = S_PROD;
      S_PROD:      state_d = S_RDIV_ST;
      S_RDIV_ST:   state_d = S_RDIV_WAIT;
      S_RDIV_WAIT: if (div_res.done) state_d = S_AVG_LO;
      S_AVG_LO:    state_d = S_AVG_HI;
      S_AVG_HI:    state_d = S_ERRMUL;
      S_ERRMUL:    state_d = S_ERR;
      S_ERR:       state_d = S_CDIV_ST;
      S_CDIV_ST:   state_d = S_CDIV_WAIT;
      S_CDIV_WAIT: if (div_res.done) state_d = S_SUM;
      S_SUM:       state_d = S_DONE;
      S_DONE:      if (out_load) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      synced_q       <= 1'b0;
      rate_avg_q     <= NominalReset;
      interval_q     <= {1'b0, NominalReset};
      base_timer_q   <= '0;
      base_ntp_q     <= '0;
      deadline_q     <= '0;
      second_count_q <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg.nominal_wr && !synced_q) begin
        rate_avg_q <= cfg.nominal;
        interval_q <= {1'b0, cfg.nominal};
      end
      if (in_xfer && s_axis_tuser) begin
        deadline_q     <= deadline_q + {{32{interval_q[31]}}, interval_q};
        second_count_q <= second_count_q + 32'd1;
      end
      if (state_q == S_SYNC) begin
        base_timer_q   <= tnow_q;
        base_ntp_q     <= ntp_us_q;
        deadline_q     <= tnow_q;
        second_count_q <= secs_q;
        synced_q       <= 1'b1;
      end
      if (state_q == S_AVG_HI) begin
        rate_avg_q <= avg_sum[65:35];
      end
      if (state_q == S_SUM) begin
        if (sum > SumMax) begin
          interval_q <= 32'h7FFF_FFFF;
        end else if (sum < SumMin) begin
          interval_q <= 32'h8000_0000;
        end else begin
          interval_q <= sum[31:0];
        end
        base_timer_q <= tnow_q;
        base_ntp_q   <= ntp_us_q;
        deadline_q   <= tnow_q;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= 52'(mul_a) * 52'(UsPerSec);
    if (in_xfer) begin
      secs_q <= s_axis_tdata[31:0];
      frac_q <= s_axis_tdata[63:32];
      tnow_q <= s_axis_tdata[127:64];
      err_q  <= 1'b0;
    end
    unique case (state_q)
      S_MUL_FRAC: ntp_us_q <= {12'b0, mul_q};
      // add floor(fraction * 1e6 / 2^32)
      S_NTP:      ntp_us_q <= ntp_us_q + {44'b0, mul_q[51:32]};
      S_DIFF: begin
        a_q   <= timer_diff[63] ? (64'd0 - timer_diff) : timer_diff;
        d_q   <= ntp_diff[63] ? (64'd0 - ntp_diff) : ntp_diff;
        neg_q <= timer_diff[63] ^ ntp_diff[63];
        err_q <= (ntp_diff == '0);
      end
      S_MUL_AHI:  prod_q <= {32'b0, mul_q};
      S_PROD:     prod_q <= prod_q + {mul_q, 32'b0};
      S_RDIV_WAIT: begin
        if (div_res.done) avg_num_q <= {1'b0, rate_avg_q, 3'b0}
                                       + {3'b0, rate_avg_q, 1'b0} + {4'b0, tps};
      end
      S_AVG_LO:   avg_prod_q <= avg_mul;
      S_ERR: begin
        emag_q <= err_diff[63] ? (64'd0 - err_diff) : err_diff;
        eneg_q <= err_diff[63];
      end
      S_CDIV_WAIT: if (div_res.done) corr_q <= div_res.quo;
      default: ;
    endcase
    if (out_load) begin
      m_data_q <= {err_q, rate_avg_q, interval_q, second_count_q, deadline_q};
    end
  end

  // divider results arrive only while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == S_RDIV_WAIT || state_q == S_CDIV_WAIT))
    else $error("divider done outside a wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser) |=> (second_count_q == $past(second_count_q) + 32'd1))
    else $error("tick did not advance the seconds count");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(synced_q))
    else $error("sync lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && m_valid_q && !m_axis_tready) |=> (state_q == S_DONE))
    else $error("result dropped while output stalled");

endmodule : ntp_disciplined_second_tick_unit
`default_nettype wire

FILE: design/ndst_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndst_div: bit-serial restoring divider
// One quotient bit per cycle over a left-aligned dividend; quotient bits that
// fall off the top of the 64-bit quotient set a sticky overflow flag.
// ----------------------------------------------------------------------------
module ndst_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ndst_pkg::DivW-1:0]     dividend_i,
  input  wire logic [63:0]                   divisor_i,
  input  wire logic [ndst_pkg::StepW-1:0]    steps_i,
  output ndst_pkg::div_res_t                 res_o
);
  import ndst_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] cnt_q;
  logic [DivW-1:0]  num_q;
  logic [63:0]      rem_q;
  logic [63:0]      dsr_q;
  logic [63:0]      quo_q;
  logic             ovf_q;

  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  logic        ge;

  assign rem_sh  = {rem_q, num_q[DivW-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[DivW-2:0], 1'b0};
      rem_q <= ge ? rem_sub[63:0] : rem_sh[63:0];
      quo_q <= {quo_q[62:0], ge};
      ovf_q <= ovf_q | quo_q[63];
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quo  = quo_q;

endmodule : ndst_div
`default_nettype wire

FILE: design/ndst_apb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndst_apb: configuration registers
// Holds the nominal rate and the pull-in divisor behind a small APB slave.
// ----------------------------------------------------------------------------
module ndst_apb (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output ndst_pkg::cfg_t   cfg_o
);
  import ndst_pkg::*;

  logic [30:0] nominal_q;
  logic [15:0] divisor_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q <= NominalReset;
      divisor_q <= DivisorReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegNominal: nominal_q <= pwdata[30:0];
        RegDivisor: divisor_q <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        RegNominal: prdata = {1'b0, nominal_q};
        RegDivisor: prdata = {16'b0, divisor_q};
        default:    prdata = '0;
      endcase
    end
  end

  // the core needs the written value in the same edge it is stored
  assign cfg_o.nominal_wr = wr_en & (paddr[2] == RegNominal);
  assign cfg_o.nominal    = pwdata[30:0];
  assign cfg_o.divisor    = divisor_q;

endmodule : ndst_apb
`default_nettype wire
